FILE: rtl/core/cms_pkg.sv
package cms_pkg;

  // default geometry of the counter store
  localparam int ROWS_DEF = 4;
  localparam int COLS_DEF = 1024;

  // field widths
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 2;
  localparam int ROWCFG_W = 3;
  localparam int COLCFG_W = 11;
  localparam int CFGIDX_W = 2;

  // remainder unit: bits retired per cycle
  localparam int DIGIT_W = 4;

  // register indexes
  localparam logic [CFGIDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFGIDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  // item modes
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] hash_a;
    logic [DATA_W-1:0] hash_b;
    logic [DATA_W-1:0] delta;
  } item_t;

endpackage

FILE: rtl/core/cms_front.sv
module cms_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       enable,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cms_pkg::MODE_W-1:0] in_mode,
  input  logic [cms_pkg::DATA_W-1:0] in_hash_a,
  input  logic [cms_pkg::DATA_W-1:0] in_hash_b,
  input  logic [cms_pkg::DATA_W-1:0] in_delta,
  output logic                       q_valid,
  output cms_pkg::item_t             q_item,
  input  logic                       q_pop
);

  cms_pkg::item_t   slot_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             xfer, push, keep;
  cms_pkg::item_t   cls;

  assign in_ready = enable && (cnt_r != 2'd2);
  assign xfer     = in_valid && in_ready;

  // classify the mode; unused mode is dropped here
  always_comb begin
    cls.hash_a = in_hash_a;
    cls.hash_b = in_hash_b;
    cls.delta  = in_delta;
    keep       = 1'b1;
    case (in_mode)
      cms_pkg::MODE_ADD:   cls.op = cms_pkg::OP_ADD;
      cms_pkg::MODE_QUERY: cls.op = cms_pkg::OP_QUERY;
      cms_pkg::MODE_CLEAR: cls.op = cms_pkg::OP_CLEAR;
      default: begin
        cls.op = cms_pkg::OP_ADD;
        keep   = 1'b0;
      end
    endcase
  end

  assign push    = xfer && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rptr_r];

  // queue pointers
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = q_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= cls;
    end
  end

endmodule

FILE: rtl/core/cms_rem.sv
module cms_rem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cms_pkg::DATA_W-1:0]   dividend,
  input  logic [cms_pkg::COLCFG_W-1:0] divisor,
  output logic                         busy,
  output logic [cms_pkg::COLCFG_W-1:0] rem
);

  localparam int STEPS = cms_pkg::DATA_W / cms_pkg::DIGIT_W;
  localparam int CW    = $clog2(STEPS + 1);
  localparam int W     = cms_pkg::COLCFG_W;

  logic [W-1:0]                rem_r, rem_nxt;
  logic [cms_pkg::DATA_W-1:0]  sh_r, sh_nxt;
  logic [W-1:0]                dv_r;
  logic [CW-1:0]               cnt_r;
  logic [W:0]                  t;

  assign busy = (cnt_r != '0);
  assign rem  = rem_r;

  // one digit of restoring remainder per cycle
  always_comb begin
    rem_nxt = rem_r;
    sh_nxt  = sh_r;
    t       = '0;
    for (int k = 0; k < cms_pkg::DIGIT_W; k++) begin
      t      = {rem_nxt, sh_nxt[cms_pkg::DATA_W-1]};
      sh_nxt = {sh_nxt[cms_pkg::DATA_W-2:0], 1'b0};
      if (t >= {1'b0, dv_r}) begin
        t = t - {1'b0, dv_r};
      end
      rem_nxt = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(STEPS);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      sh_r  <= dividend;
      dv_r  <= divisor;
    end else if (busy) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
    end
  end

endmodule

FILE: rtl/core/cms_back.sv
module cms_back #(
  parameter int ROWS    = cms_pkg::ROWS_DEF,
  parameter int COLUMNS = cms_pkg::COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cms_pkg::ROWCFG_W-1:0] rows_act,
  input  logic [cms_pkg::COLCFG_W-1:0] cols_act,
  input  logic                         q_valid,
  input  cms_pkg::item_t               q_item,
  output logic                         q_pop,
  output logic                         init_done,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cms_pkg::DATA_W-1:0]   out_estimate
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int W     = cms_pkg::COLCFG_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SWEEP = 6'b000010,
    S_DIV   = 6'b000100,
    S_RD    = 6'b001000,
    S_UPD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t                      state_r, state_nxt;
  logic                        init_done_r;
  logic [AW-1:0]               sweep_r;
  logic [AW-1:0]               base_r;
  logic [W-1:0]                col_r, stride_r;
  logic [cms_pkg::ROWCFG_W-1:0] row_r;
  cms_pkg::op_t                op_r;
  logic [cms_pkg::DATA_W-1:0]  delta_r, best_r, rd_q;
  logic [cms_pkg::DATA_W-1:0]  mem [DEPTH];
  logic                        busy_a, busy_b;
  logic [W-1:0]                rem_a, rem_b;
  logic                        start;
  logic [AW-1:0]               addr, waddr;
  logic                        we;
  logic [cms_pkg::DATA_W-1:0]  wdata;
  logic [W:0]                  col_sum;
  logic                        last_row, sweep_end;

  assign q_pop        = (state_r == S_IDLE) && q_valid;
  assign start        = q_pop && (q_item.op != cms_pkg::OP_CLEAR);
  assign init_done    = init_done_r;
  assign out_valid    = (state_r == S_OUT);
  assign out_estimate = best_r;
  assign addr         = base_r + AW'(col_r);
  assign last_row     = (row_r == rows_act - 1'b1);
  assign sweep_end    = (sweep_r == AW'(DEPTH - 1));
  assign col_sum      = {1'b0, col_r} + {1'b0, stride_r};

  // column remainders of both hashes
  cms_rem u_rem_a (
    .clk(clk), .rst_n(rst_n), .start(start), .dividend(q_item.hash_a),
    .divisor(cols_act), .busy(busy_a), .rem(rem_a)
  );

  cms_rem u_rem_b (
    .clk(clk), .rst_n(rst_n), .start(start), .dividend(q_item.hash_b),
    .divisor(cols_act), .busy(busy_b), .rem(rem_b)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_item.op == cms_pkg::OP_CLEAR) ? S_SWEEP : S_DIV;
        end
      end
      S_SWEEP: if (sweep_end) state_nxt = S_IDLE;
      S_DIV:   if (!busy_a && !busy_b) state_nxt = S_RD;
      S_RD:    state_nxt = S_UPD;
      S_UPD: begin
        if (!last_row) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = (op_r == cms_pkg::OP_QUERY) ? S_OUT : S_IDLE;
        end
      end
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      init_done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SWEEP) begin
        sweep_r <= sweep_end ? '0 : sweep_r + 1'b1;
        if (sweep_end) begin
          init_done_r <= 1'b1;
        end
      end
    end
  end

  // per-row walk: column steps by stride modulo the column count
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r    <= q_item.op;
      delta_r <= q_item.delta;
    end
    if (state_r == S_DIV) begin
      col_r    <= rem_a;
      stride_r <= rem_b;
      row_r    <= '0;
      base_r   <= '0;
    end
    if (state_r == S_UPD) begin
      row_r  <= row_r + 1'b1;
      base_r <= base_r + AW'(COLUMNS);
      col_r  <= (col_sum >= {1'b0, cols_act}) ? W'(col_sum - {1'b0, cols_act})
                                              : col_sum[W-1:0];
      if (row_r == '0 || rd_q < best_r) begin
        best_r <= rd_q;
      end
    end
  end

  // counter store
  assign we    = (state_r == S_SWEEP) || ((state_r == S_UPD) && (op_r == cms_pkg::OP_ADD));
  assign waddr = (state_r == S_SWEEP) ? sweep_r : addr;
  assign wdata = (state_r == S_SWEEP) ? '0 : rd_q + delta_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[addr];
  end

endmodule

FILE: rtl/core/count_min_sketch_table.sv
// channel  | direction | ports
// in_      | input     | in_valid, in_ready, in_mode, in_hash_a, in_hash_b, in_delta
// out_     | output    | out_valid, out_ready, out_estimate
// cfg_     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// add takes one pop, a wait on the 4-bit-per-cycle remainder unit
// (8 digits and the load of the columns), then a read and an update
// per active row through the single store port; query also holds its
// result until taken.
// clear and the pass after reset walk the store one counter a cycle,
// over every counter; in_ready stays low during the pass after reset.
// a two-entry queue lets items be taken while the back end is busy.
module count_min_sketch_table #(
  parameter int ROWS    = cms_pkg::ROWS_DEF,
  parameter int COLUMNS = cms_pkg::COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cms_pkg::MODE_W-1:0]   in_mode,
  input  logic [cms_pkg::DATA_W-1:0]   in_hash_a,
  input  logic [cms_pkg::DATA_W-1:0]   in_hash_b,
  input  logic [cms_pkg::DATA_W-1:0]   in_delta,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cms_pkg::DATA_W-1:0]   out_estimate,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cms_pkg::CFGIDX_W-1:0] cfg_index,
  input  logic [cms_pkg::COLCFG_W-1:0] cfg_data
);

  logic [cms_pkg::ROWCFG_W-1:0] row_count_r;
  logic [cms_pkg::COLCFG_W-1:0] column_count_r;
  logic [cms_pkg::ROWCFG_W-1:0] rows_act;
  logic [cms_pkg::COLCFG_W-1:0] cols_act;
  logic                         q_valid, q_pop, init_done;
  cms_pkg::item_t               q_item;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= cms_pkg::ROWCFG_W'(4);
      column_count_r <= cms_pkg::COLCFG_W'(1024);
    end else if (cfg_valid) begin
      case (cfg_index)
        cms_pkg::REG_ROW_COUNT:    row_count_r    <= cfg_data[cms_pkg::ROWCFG_W-1:0];
        cms_pkg::REG_COLUMN_COUNT: column_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to the built geometry
  always_comb begin
    if (row_count_r == '0) begin
      rows_act = cms_pkg::ROWCFG_W'(1);
    end else if (32'(row_count_r) > ROWS) begin
      rows_act = cms_pkg::ROWCFG_W'(ROWS);
    end else begin
      rows_act = row_count_r;
    end
    if (column_count_r == '0) begin
      cols_act = cms_pkg::COLCFG_W'(1);
    end else if (32'(column_count_r) > COLUMNS) begin
      cols_act = cms_pkg::COLCFG_W'(COLUMNS);
    end else begin
      cols_act = column_count_r;
    end
  end

  cms_front u_front (
    .clk(clk), .rst_n(rst_n), .enable(init_done),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_hash_a(in_hash_a), .in_hash_b(in_hash_b), .in_delta(in_delta),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  cms_back #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_back (
    .clk(clk), .rst_n(rst_n), .rows_act(rows_act), .cols_act(cols_act),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .init_done(init_done),
    .out_valid(out_valid), .out_ready(out_ready), .out_estimate(out_estimate)
  );

endmodule

FILE: tb/tb_count_min_sketch_table.sv
module tb_count_min_sketch_table;

  localparam int                           NROWS       = cms_pkg::ROWS_DEF;
  localparam int                           NCOLS       = cms_pkg::COLS_DEF;
  localparam logic [cms_pkg::MODE_W-1:0]   MODE_UNUSED = 2'd3;
  localparam logic [cms_pkg::CFGIDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [cms_pkg::CFGIDX_W-1:0] REG_SPARE_3 = 2'd3;
  // up to three clears in flight: one in the back end, two queued
  localparam int                           SETTLE_CYC  = 3 * NROWS * NCOLS + 200;
  localparam longint                       CYCLE_LIMIT = 3000000;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [cms_pkg::MODE_W-1:0]   in_mode;
  logic [cms_pkg::DATA_W-1:0]   in_hash_a;
  logic [cms_pkg::DATA_W-1:0]   in_hash_b;
  logic [cms_pkg::DATA_W-1:0]   in_delta;
  logic                         out_valid;
  logic                         out_ready;
  logic [cms_pkg::DATA_W-1:0]   out_estimate;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [cms_pkg::CFGIDX_W-1:0] cfg_index;
  logic [cms_pkg::COLCFG_W-1:0] cfg_data;

  // predictor state
  bit [cms_pkg::DATA_W-1:0]   sketch [NROWS][NCOLS];
  bit [cms_pkg::ROWCFG_W-1:0] row_reg;
  bit [cms_pkg::COLCFG_W-1:0] col_reg;
  bit [cms_pkg::DATA_W-1:0]   pending_estimates[$];
  int                         mismatches;
  longint                     cycles = 0;
  bit                         steady;       // no idling on either side
  bit [cms_pkg::DATA_W-1:0]   key_a [8];
  bit [cms_pkg::DATA_W-1:0]   key_b [8];

  count_min_sketch_table u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_hash_a    (in_hash_a),
    .in_hash_b    (in_hash_b),
    .in_delta     (in_delta),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_estimate (out_estimate),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report(input string what, input bit [cms_pkg::DATA_W-1:0] got,
                        input bit [cms_pkg::DATA_W-1:0] want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
  endtask

  // sketch model: updates the counters and queues the query estimate
  task automatic sketch_apply(input logic [cms_pkg::MODE_W-1:0] m,
                              input bit [cms_pkg::DATA_W-1:0] ha,
                              input bit [cms_pkg::DATA_W-1:0] hb,
                              input bit [cms_pkg::DATA_W-1:0] d);
    int unsigned              rows;
    int unsigned              cols;
    bit [63:0]                sum;
    int unsigned              col;
    bit [cms_pkg::DATA_W-1:0] lowest;
    rows = (row_reg == 0) ? 1 : (row_reg > NROWS) ? NROWS : row_reg;
    cols = (col_reg == 0) ? 1 : (col_reg > NCOLS) ? NCOLS : col_reg;
    lowest = '1;
    case (m)
      cms_pkg::MODE_ADD, cms_pkg::MODE_QUERY: begin
        for (int r = 0; r < rows; r++) begin
          sum = {32'd0, ha} + 64'(r) * {32'd0, hb};
          col = int'(sum % 64'(cols));
          if (m == cms_pkg::MODE_ADD) sketch[r][col] += d;
          else if (sketch[r][col] < lowest) lowest = sketch[r][col];
        end
        if (m == cms_pkg::MODE_QUERY) pending_estimates.push_back(lowest);
      end
      cms_pkg::MODE_CLEAR: begin
        foreach (sketch[r, c]) sketch[r][c] = '0;
      end
      default: ;
    endcase
  endtask

  // one input transfer; valid stays up when the next item follows at once
  task automatic send_item(input logic [cms_pkg::MODE_W-1:0] m,
                           input bit [cms_pkg::DATA_W-1:0] ha,
                           input bit [cms_pkg::DATA_W-1:0] hb,
                           input bit [cms_pkg::DATA_W-1:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_mode   <= m;
    in_hash_a <= ha;
    in_hash_b <= hb;
    in_delta  <= d;
    do @(posedge clk); while (!in_ready);
    sketch_apply(m, ha, hb, d);
  endtask

  // wait for all estimates and for any clear to finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cms_pkg::CFGIDX_W-1:0] idx,
                           input bit [cms_pkg::COLCFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == cms_pkg::REG_ROW_COUNT) row_reg = val[cms_pkg::ROWCFG_W-1:0];
    else if (idx == cms_pkg::REG_COLUMN_COUNT) col_reg = val;
    @(posedge clk);
  endtask

  task automatic configure(input bit [cms_pkg::COLCFG_W-1:0] rows,
                           input bit [cms_pkg::COLCFG_W-1:0] cols);
    settle();
    write_reg(cms_pkg::REG_ROW_COUNT, rows);
    write_reg(cms_pkg::REG_COLUMN_COUNT, cols);
  endtask

  // counters start at zero after reset
  task automatic test_reset_state();
    send_item(cms_pkg::MODE_QUERY, 32'd0, 32'd0, 32'd0);
    send_item(cms_pkg::MODE_QUERY, '1, '1, '1);
  endtask

  // field extremes, counter wrap, every mode
  task automatic test_modes();
    send_item(cms_pkg::MODE_ADD, '1, '1, '1);
    send_item(cms_pkg::MODE_QUERY, '1, '1, 32'd0);
    send_item(cms_pkg::MODE_ADD, '1, '1, 32'd2);
    send_item(cms_pkg::MODE_QUERY, '1, '1, '1);
    send_item(cms_pkg::MODE_ADD, 32'd0, 32'd0, 32'h8000_0001);
    send_item(cms_pkg::MODE_ADD, 32'd1024, 32'd0, 32'h7fff_ffff);
    send_item(cms_pkg::MODE_QUERY, 32'd0, 32'd0, 32'd0);
    send_item(MODE_UNUSED, 32'd0, 32'd0, 32'h1234_5678);
    send_item(cms_pkg::MODE_QUERY, 32'd0, 32'd0, 32'd0);
    send_item(cms_pkg::MODE_ADD, 32'h5555_5555, 32'haaaa_aaaa, 32'd7);
    send_item(cms_pkg::MODE_QUERY, 32'h5555_5555, 32'haaaa_aaaa, 32'd0);
    send_item(cms_pkg::MODE_CLEAR, '1, '1, '1);
    send_item(cms_pkg::MODE_QUERY, 32'd0, 32'd0, 32'd0);
    send_item(cms_pkg::MODE_QUERY, 32'h5555_5555, 32'haaaa_aaaa, 32'd0);
  endtask

  // register extremes, unused indexes, store kept across changes
  task automatic test_registers();
    configure(11'd1, 11'd1);
    send_item(cms_pkg::MODE_ADD, 32'h0000_0003, 32'd9, 32'd5);
    send_item(cms_pkg::MODE_QUERY, '1, 32'd1, 32'd0);
    configure(11'd0, 11'd0);
    send_item(cms_pkg::MODE_QUERY, 32'd77, 32'd3, 32'd0);
    configure(11'd7, 11'd2047);
    send_item(cms_pkg::MODE_QUERY, 32'd0, 32'd0, 32'd0);
    settle();
    write_reg(REG_SPARE_2, 11'h7ff);
    write_reg(REG_SPARE_3, 11'h555);
    send_item(cms_pkg::MODE_QUERY, 32'd0, 32'd0, 32'd0);
    configure(11'd3, 11'd1000);
    send_item(cms_pkg::MODE_ADD, '1, 32'h8000_0000, 32'd11);
    send_item(cms_pkg::MODE_QUERY, '1, 32'h8000_0000, 32'd0);
  endtask

  // random traffic on a few keys per phase so queries hit live counters
  task automatic test_random();
    int                         pick;
    int                         k;
    logic [cms_pkg::MODE_W-1:0] m;
    bit [cms_pkg::DATA_W-1:0]   ha;
    bit [cms_pkg::DATA_W-1:0]   hb;
    bit [cms_pkg::DATA_W-1:0]   d;
    bit [cms_pkg::COLCFG_W-1:0] col_choice [6];
    col_choice = '{11'd1, 11'd2, 11'd7, 11'd1000, 11'd1024, 11'd0};
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 3) configure(11'(NROWS), 11'(NCOLS));
      else configure(11'($urandom_range(0, 7)),
                     ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                                 : col_choice[$urandom_range(0, 5)]);
      foreach (key_a[i]) begin
        key_a[i] = $urandom();
        key_b[i] = $urandom();
      end
      for (int n = 0; n < 100; n++) begin
        steady = (n >= 40 && n < 60);
        if (n == 70) settle();
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, 7);
        ha   = key_a[k];
        hb   = key_b[k];
        if ($urandom_range(0, 4) == 0) begin
          ha = $urandom();
          hb = $urandom();
        end
        d = ($urandom_range(0, 2) == 0) ? $urandom() : 32'($urandom_range(0, 255));
        if (pick < 50) m = cms_pkg::MODE_ADD;
        else if (pick < 94) m = cms_pkg::MODE_QUERY;
        else if (pick < 97) m = cms_pkg::MODE_CLEAR;
        else m = MODE_UNUSED;
        send_item(m, ha, hb, d);
      end
    end
    steady = 1'b0;
  endtask

  // receiver stalls
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // result checker on each output transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_estimates.size() == 0) begin
        report("unexpected estimate", out_estimate, '0);
      end else begin
        if (out_estimate !== pending_estimates[0])
          report("estimate", out_estimate, pending_estimates[0]);
        void'(pending_estimates.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_mode    = cms_pkg::MODE_ADD;
    in_hash_a  = '0;
    in_hash_b  = '0;
    in_delta   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = cms_pkg::REG_ROW_COUNT;
    cfg_data   = '0;
    mismatches = 0;
    steady     = 1'b0;
    row_reg    = 3'd4;
    col_reg    = 11'd1024;
    foreach (sketch[r, c]) sketch[r][c] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_modes();
    test_registers();
    test_random();
    settle();
    if (mismatches == 0 && pending_estimates.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending_estimates.size() != 0)
        $display("%0d estimates never arrived", pending_estimates.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/cms_pkg.sv
rtl/core/cms_front.sv
rtl/core/cms_rem.sv
rtl/core/cms_back.sv
rtl/core/count_min_sketch_table.sv
tb/tb_count_min_sketch_table.sv
